@@ hdl/pidc_pkg.sv @@
// ----------------------------------------------------------------------------
// PID controller package
// Widths, codes, register map and sequencer states of the clamped PID block.
// ----------------------------------------------------------------------------
package pidc_pkg;

	localparam int DATA_W   = 16;
	localparam int INTEG_W  = 32;
	localparam int ADDR_W   = 5;
	localparam int PDATA_W  = 32;
	localparam int MUL_A_W  = 17;
	localparam int MUL_B_W  = 33;
	localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
	localparam int ACC_W    = 48;
	localparam int DIV_BITS = 46;
	localparam int CNT_W    = $clog2(DIV_BITS);
	localparam int OUT_W    = ACC_W - 8;

	localparam logic [DATA_W-1:0] DT_MIN = 16'd17;
	localparam logic [DATA_W-1:0] DT_ONE = 16'd16384;

	typedef enum logic [1:0] {
		CLAMP_NONE  = 2'd0,
		CLAMP_UPPER = 2'd1,
		CLAMP_LOWER = 2'd2
	} clamp_status_t;

	typedef enum logic [2:0] {
		REG_KP    = 3'd0,
		REG_KI    = 3'd1,
		REG_KD    = 3'd2,
		REG_UPPER = 3'd3,
		REG_LOWER = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL_I,
		S_INTEG,
		S_ACC_P,
		S_ACC_I,
		S_DIV_PREP,
		S_DIV,
		S_SUM
	} state_t;

endpackage

@@ hdl/pidc_if.sv @@
// ----------------------------------------------------------------------------
// PID controller channels
// Valid/ready channels for error samples and for control results.
// ----------------------------------------------------------------------------
interface pidc_in_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [pidc_pkg::DATA_W-1:0]    error_sample;
	logic        [pidc_pkg::DATA_W-1:0]    time_step;

	modport source (output valid, output error_sample, output time_step, input ready);
	modport sink   (input valid, input error_sample, input time_step, output ready);
endinterface

interface pidc_out_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [pidc_pkg::DATA_W-1:0]    control_value;
	logic        [1:0]                     clamp_status;

	modport source (output valid, output control_value, output clamp_status, input ready);
	modport sink   (input valid, input control_value, input clamp_status, output ready);
endinterface

@@ hdl/pid_controller_clamped.sv @@
// ----------------------------------------------------------------------------
// Clamped PID controller
// Fixed-point PID with saturating integral and output limits, one shared
// multiplier and a bit-serial divider for the derivative term.
// ----------------------------------------------------------------------------
// Usage:
// An item on the sample channel carries one error sample (signed Q8.8) and the
// time step (unsigned Q2.14). The block answers each item with one item on the
// result channel: the clamped output (signed Q8.8) and the clamp status.
// Gains and limits must be written over the APB port only while the block is
// idle; the block itself does not enforce this. An accepted item runs
// through the multiply and accumulate steps on the shared multiplier
// (S_MUL_I, S_INTEG, S_ACC_P, S_ACC_I) and the divider set-up, then 46 steps
// of the restoring divider that scales the derivative term by the time step,
// and a final add, round and clamp step, before a new item is accepted.
// sample.ready is high only while the sequencer is idle.
// The result sits in an output register; if it is still waiting when the next
// item finishes, that item holds in its last step until the receiver takes it.
// Reset clears the gains, sets the limits to the full range and clears the
// error integral and the previous error.
// ----------------------------------------------------------------------------
module pid_controller_clamped (
	input  logic                               clk,
	input  logic                               arst_n,
	pidc_in_if.sink                            sample,
	pidc_out_if.source                         result,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [pidc_pkg::ADDR_W-1:0]        paddr,
	input  logic [pidc_pkg::PDATA_W-1:0]       pwdata,
	output logic [pidc_pkg::PDATA_W-1:0]       prdata,
	output logic                               pready
);

	localparam logic signed [33:0] INTEG_MAX = 34'sh0_7FFF_FFFF;
	localparam logic signed [33:0] INTEG_MIN = -34'sh0_8000_0000;

	pidc_pkg::state_t state_q, state_d;

	logic signed [pidc_pkg::DATA_W-1:0]  kp_q, ki_q, kd_q, upper_q, lower_q;
	logic signed [pidc_pkg::DATA_W-1:0]  prev_q, e_q;
	logic        [pidc_pkg::DATA_W-1:0]  dt_q, dt_eff;
	logic signed [pidc_pkg::INTEG_W-1:0] integral_q, integ_sat;
	logic signed [33:0]                  integ_inc, integ_sum;

	logic signed [pidc_pkg::MUL_A_W-1:0] mul_a;
	logic signed [pidc_pkg::MUL_B_W-1:0] mul_b;
	logic signed [pidc_pkg::MUL_P_W-1:0] mul_p, prod_q;

	logic signed [pidc_pkg::ACC_W-1:0]   acc_q, i_term, num, num_mag, quo_sig, sum;
	logic        [pidc_pkg::DIV_BITS-1:0] quo_q;
	logic        [pidc_pkg::DATA_W-1:0]  rem_q;
	logic        [pidc_pkg::DATA_W:0]    trial;
	logic                                trial_ge;
	logic                                neg_q;
	logic        [pidc_pkg::CNT_W-1:0]   cnt_q;

	logic signed [pidc_pkg::OUT_W-1:0]   v;
	logic signed [pidc_pkg::DATA_W-1:0]  v_clamped;
	pidc_pkg::clamp_status_t             status;

	logic                                out_valid_q;
	logic signed [pidc_pkg::DATA_W-1:0]  out_value_q;
	pidc_pkg::clamp_status_t             out_status_q;
	logic                                sum_go;
	logic                                cfg_wr;
	pidc_pkg::reg_idx_t                  cfg_idx;

	// Configuration port.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = pidc_pkg::reg_idx_t'(paddr[4:2]);

	always_comb begin
		case (cfg_idx)
			pidc_pkg::REG_KP:    prdata = 32'(kp_q);
			pidc_pkg::REG_KI:    prdata = 32'(ki_q);
			pidc_pkg::REG_KD:    prdata = 32'(kd_q);
			pidc_pkg::REG_UPPER: prdata = 32'(upper_q);
			pidc_pkg::REG_LOWER: prdata = 32'(lower_q);
			default:             prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q    <= '0;
			ki_q    <= '0;
			kd_q    <= '0;
			upper_q <= 16'sh7FFF;
			lower_q <= -16'sh8000;
		end else if (cfg_wr) begin
			case (cfg_idx)
				pidc_pkg::REG_KP:    kp_q    <= signed'(pwdata[15:0]);
				pidc_pkg::REG_KI:    ki_q    <= signed'(pwdata[15:0]);
				pidc_pkg::REG_KD:    kd_q    <= signed'(pwdata[15:0]);
				pidc_pkg::REG_UPPER: upper_q <= signed'(pwdata[15:0]);
				pidc_pkg::REG_LOWER: lower_q <= signed'(pwdata[15:0]);
				default: ;
			endcase
		end
	end

	// Shared multiplier.
	assign mul_p = mul_a * mul_b;

	// Combinational datapath.
	assign dt_eff    = (dt_q < pidc_pkg::DT_MIN) ? pidc_pkg::DT_ONE : dt_q;
	assign integ_inc = 34'((prod_q + 50'sd32) >>> 6);
	assign integ_sum = {{2{integral_q[31]}}, integral_q} + integ_inc;

	always_comb begin
		if (integ_sum > INTEG_MAX) begin
			integ_sat = 32'sh7FFF_FFFF;
		end else if (integ_sum < INTEG_MIN) begin
			integ_sat = -32'sh8000_0000;
		end else begin
			integ_sat = integ_sum[31:0];
		end
	end

	assign i_term   = 48'((prod_q + 50'sd128) >>> 8);
	assign num      = signed'({prod_q[33:0], 14'b0}) + signed'({33'b0, dt_eff[15:1]});
	assign num_mag  = num[47] ? ~num : num;
	assign trial    = {rem_q, quo_q[pidc_pkg::DIV_BITS-1]};
	assign trial_ge = trial >= {1'b0, dt_eff};
	assign quo_sig  = neg_q ? ~signed'({2'b0, quo_q}) : signed'({2'b0, quo_q});
	assign sum      = acc_q + quo_sig;
	assign v        = pidc_pkg::OUT_W'((sum + 48'sd128) >>> 8);

	always_comb begin
		if (v > pidc_pkg::OUT_W'(upper_q)) begin
			v_clamped = upper_q;
			status    = pidc_pkg::CLAMP_UPPER;
		end else if (v < pidc_pkg::OUT_W'(lower_q)) begin
			v_clamped = lower_q;
			status    = pidc_pkg::CLAMP_LOWER;
		end else begin
			v_clamped = v[15:0];
			status    = pidc_pkg::CLAMP_NONE;
		end
	end

	assign sum_go = (state_q == pidc_pkg::S_SUM) && (!out_valid_q || result.ready);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			pidc_pkg::S_IDLE:     if (sample.valid) state_d = pidc_pkg::S_MUL_I;
			pidc_pkg::S_MUL_I:    state_d = pidc_pkg::S_INTEG;
			pidc_pkg::S_INTEG:    state_d = pidc_pkg::S_ACC_P;
			pidc_pkg::S_ACC_P:    state_d = pidc_pkg::S_ACC_I;
			pidc_pkg::S_ACC_I:    state_d = pidc_pkg::S_DIV_PREP;
			pidc_pkg::S_DIV_PREP: state_d = pidc_pkg::S_DIV;
			pidc_pkg::S_DIV:      if (cnt_q == '0) state_d = pidc_pkg::S_SUM;
			pidc_pkg::S_SUM:      if (sum_go) state_d = pidc_pkg::S_IDLE;
			default:              state_d = pidc_pkg::S_IDLE;
		endcase
	end

	// Sequencer outputs: input handshake and multiplier operands.
	always_comb begin
		sample.ready = 1'b0;
		mul_a        = '0;
		mul_b        = '0;
		case (state_q)
			pidc_pkg::S_IDLE: begin
				sample.ready = 1'b1;
			end
			pidc_pkg::S_MUL_I: begin
				mul_a = {e_q[15], e_q};
				mul_b = signed'({17'b0, dt_q});
			end
			pidc_pkg::S_INTEG: begin
				mul_a = {e_q[15], e_q};
				mul_b = {{17{kp_q[15]}}, kp_q};
			end
			pidc_pkg::S_ACC_P: begin
				mul_a = {ki_q[15], ki_q};
				mul_b = {integral_q[31], integral_q};
			end
			pidc_pkg::S_ACC_I: begin
				mul_a = {e_q[15], e_q} - {prev_q[15], prev_q};
				mul_b = {{17{kd_q[15]}}, kd_q};
			end
			default: ;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pidc_pkg::S_IDLE;
			cnt_q       <= '0;
			integral_q  <= '0;
			prev_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == pidc_pkg::S_INTEG) begin
				integral_q <= integ_sat;
			end
			if (state_q == pidc_pkg::S_ACC_I) begin
				prev_q <= e_q;
			end
			if (state_q == pidc_pkg::S_DIV_PREP) begin
				cnt_q <= pidc_pkg::CNT_W'(pidc_pkg::DIV_BITS - 1);
			end else if (state_q == pidc_pkg::S_DIV) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (sum_go) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			e_q  <= sample.error_sample;
			dt_q <= sample.time_step;
		end
		prod_q <= mul_p;
		case (state_q)
			pidc_pkg::S_ACC_P: acc_q <= prod_q[47:0];
			pidc_pkg::S_ACC_I: acc_q <= acc_q + i_term;
			pidc_pkg::S_DIV_PREP: begin
				neg_q <= num[47];
				quo_q <= num_mag[pidc_pkg::DIV_BITS-1:0];
				rem_q <= '0;
			end
			pidc_pkg::S_DIV: begin
				rem_q <= trial_ge ? 16'(trial - {1'b0, dt_eff}) : trial[15:0];
				quo_q <= {quo_q[pidc_pkg::DIV_BITS-2:0], trial_ge};
			end
			default: ;
		endcase
		if (sum_go) begin
			out_value_q  <= v_clamped;
			out_status_q <= status;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.control_value = out_value_q;
	assign result.clamp_status  = out_status_q;

`ifndef SYNTH
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> state_q == pidc_pkg::S_MUL_I)
		else $error("Accepted item did not start the sequencer.");

	a_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pidc_pkg::S_DIV |-> rem_q < dt_eff)
		else $error("Divider remainder is not below the divisor.");

	a_upper: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.clamp_status == pidc_pkg::CLAMP_UPPER
			|-> result.control_value == upper_q)
		else $error("Upper clamp status without the upper limit.");

	a_inside: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.clamp_status == pidc_pkg::CLAMP_NONE
			|-> result.control_value <= upper_q && result.control_value >= lower_q)
		else $error("Unclamped output lies outside the limits.");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pidc_pkg::S_SUM && out_valid_q && !result.ready
			|=> state_q == pidc_pkg::S_SUM)
		else $error("Result register overwritten while stalled.");
`endif

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// Clamped PID controller testbench
// Drives error samples through the valid/ready channel while the result side
// stalls on its own pattern, and programs gains and limits over APB between
// phases. A directed table covers reset values, field extremes, the tiny time
// step, inverted limits and unmapped register writes. Random phases then sweep
// gain and limit settings, including integral windup in both directions. A
// software copy of the fixed-point controller predicts each result, and every
// result is checked field by field in order.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [pidc_pkg::DATA_W-1:0] word_t;

	localparam int     CYCLE_LIMIT   = 1000000;
	localparam int     TAIL_CYCLES   = 64;
	localparam int     NUM_PHASES    = 12;
	localparam int     PHASE_ITEMS   = 154;
	localparam int     DIR_ROWS      = 25;
	localparam longint TINY_DT_LIMIT = 17;
	localparam longint UNIT_DT       = 16384;
	localparam longint INTEG_MAX     = 2147483647;
	localparam longint INTEG_MIN     = -INTEG_MAX - 1;
	localparam logic [2:0] IDX_KP          = pidc_pkg::REG_KP;
	localparam logic [2:0] IDX_KI          = pidc_pkg::REG_KI;
	localparam logic [2:0] IDX_KD          = pidc_pkg::REG_KD;
	localparam logic [2:0] IDX_UPPER       = pidc_pkg::REG_UPPER;
	localparam logic [2:0] IDX_LOWER       = pidc_pkg::REG_LOWER;
	localparam logic [2:0] UNMAPPED_IDX_LO = 3'd5;
	localparam logic [2:0] UNMAPPED_IDX_HI = 3'd7;
	localparam pidc_pkg::clamp_status_t ST_NONE  = pidc_pkg::CLAMP_NONE;
	localparam pidc_pkg::clamp_status_t ST_UPPER = pidc_pkg::CLAMP_UPPER;
	localparam pidc_pkg::clamp_status_t ST_LOWER = pidc_pkg::CLAMP_LOWER;

	typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

	typedef struct packed {
		word_t                   control_value;
		pidc_pkg::clamp_status_t clamp_status;
	} pid_out_t;

	typedef struct packed {
		row_kind_t               kind;
		logic [2:0]              reg_idx;
		word_t                   wdata;
		word_t                   err;
		word_t                   dt;
		logic                    typed;
		word_t                   exp_value;
		pidc_pkg::clamp_status_t exp_status;
	} stim_row_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [pidc_pkg::ADDR_W-1:0]    paddr;
	logic [pidc_pkg::PDATA_W-1:0]   pwdata;
	logic [pidc_pkg::PDATA_W-1:0]   prdata;
	logic                           pready;

	pidc_in_if  sample_ch();
	pidc_out_if result_ch();

	pid_controller_clamped dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Controller copy: configuration and loop state.
	logic signed [pidc_pkg::DATA_W-1:0]  cfg_kp    = '0;
	logic signed [pidc_pkg::DATA_W-1:0]  cfg_ki    = '0;
	logic signed [pidc_pkg::DATA_W-1:0]  cfg_kd    = '0;
	logic signed [pidc_pkg::DATA_W-1:0]  cfg_upper = 16'sh7FFF;
	logic signed [pidc_pkg::DATA_W-1:0]  cfg_lower = 16'sh8000;
	logic signed [pidc_pkg::DATA_W-1:0]  prev_err  = '0;
	logic signed [pidc_pkg::INTEG_W-1:0] integ_acc = '0;

	pid_out_t  pending_outputs[$];
	stim_row_t dir_rows [DIR_ROWS];

	int  fail_count    = 0;
	int  cycle_count   = 0;
	int  samples_sent  = 0;
	int  results_seen  = 0;
	int  sat_hits      = 0;
	int  status_hits [3] = '{0, 0, 0};
	int  burst_left    = 0;
	bit  gaps_on       = 1'b1;
	int  rdy_hold      = 0;
	bit  rdy_level     = 1'b0;

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic longint round_div(input longint x, input longint d);
		longint y;
		longint q;
		y = x + d / 2;
		q = y / d;
		if ((y % d) != 0 && y < 0)
			q--;
		return q;
	endfunction

	function automatic pid_out_t pid_step_predict(input word_t err_bits,
			input word_t dt_bits);
		longint   e;
		longint   dt_raw;
		longint   dt_div;
		longint   integ;
		longint   p_term;
		longint   i_term;
		longint   d_term;
		longint   v;
		pid_out_t r;
		e      = longint'($signed(err_bits));
		dt_raw = longint'(dt_bits);
		dt_div = (dt_raw < TINY_DT_LIMIT) ? UNIT_DT : dt_raw;
		integ  = longint'(integ_acc) + round_div(e * dt_raw, 64);
		if (integ > INTEG_MAX) begin
			integ = INTEG_MAX;
			sat_hits++;
		end else if (integ < INTEG_MIN) begin
			integ = INTEG_MIN;
			sat_hits++;
		end
		integ_acc = pidc_pkg::INTEG_W'(integ);
		p_term = longint'(cfg_kp) * e;
		i_term = round_div(longint'(cfg_ki) * integ, 256);
		d_term = round_div(longint'(cfg_kd) * (e - longint'(prev_err)) * UNIT_DT, dt_div);
		v = round_div(p_term + i_term + d_term, 256);
		r.clamp_status = ST_NONE;
		if (v > longint'(cfg_upper)) begin
			v = longint'(cfg_upper);
			r.clamp_status = ST_UPPER;
		end else if (v < longint'(cfg_lower)) begin
			v = longint'(cfg_lower);
			r.clamp_status = ST_LOWER;
		end
		r.control_value = word_t'(v);
		prev_err = err_bits;
		return r;
	endfunction

	function automatic word_t pick_gain();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 16'h7FFF;
			2: return 16'h8000;
			3: return word_t'(int'($urandom_range(0, 1024)) - 512);
			default: return word_t'($urandom);
		endcase
	endfunction

	task automatic reg_write(input logic [2:0] idx, input word_t value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= pidc_pkg::ADDR_W'({idx, 2'b00});
		pwdata  <= pidc_pkg::PDATA_W'($signed(value));
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			IDX_KP:    cfg_kp    = value;
			IDX_KI:    cfg_ki    = value;
			IDX_KD:    cfg_kd    = value;
			IDX_UPPER: cfg_upper = value;
			IDX_LOWER: cfg_lower = value;
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic wait_idle();
		sample_ch.valid <= 1'b0;
		while (pending_outputs.size() != 0)
			@(negedge clk);
	endtask

	task automatic send_sample(input word_t err, input word_t dt,
			input bit typed, input pid_out_t typed_out);
		pid_out_t predicted;
		int       gap;
		sample_ch.valid        <= 1'b1;
		sample_ch.error_sample <= err;
		sample_ch.time_step    <= dt;
		do @(posedge clk); while (!sample_ch.ready);
		predicted = pid_step_predict(err, dt);
		pending_outputs.push_back(typed ? typed_out : predicted);
		samples_sent++;
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = gaps_on ? int'($urandom_range(1, 20)) : 0;
			if (gap > 0) begin
				sample_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(0, 7);
		end
	endtask

	always @(negedge clk) begin
		if (rdy_hold == 0) begin
			case ($urandom_range(0, 5))
				0: begin
					rdy_level = 1'b1;
					rdy_hold  = $urandom_range(100, 300);
				end
				1, 2: begin
					rdy_level = 1'b0;
					rdy_hold  = $urandom_range(1, 30);
				end
				default: begin
					rdy_level = 1'b1;
					rdy_hold  = $urandom_range(1, 20);
				end
			endcase
		end else begin
			rdy_hold--;
		end
		result_ch.ready <= arst_n ? rdy_level : 1'b0;
	end

	always @(posedge clk) begin : check_results
		pid_out_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			results_seen++;
			if (pending_outputs.size() == 0) begin
				$error("result item with no sample pending: control_value %0d",
					$signed(result_ch.control_value));
				fail_count++;
			end else begin
				want = pending_outputs.pop_front();
				if (want.clamp_status <= ST_LOWER)
					status_hits[want.clamp_status]++;
				if (result_ch.control_value !== want.control_value) begin
					$error("control_value: expected %0d, got %0d",
						$signed(want.control_value), $signed(result_ch.control_value));
					fail_count++;
				end
				if (result_ch.clamp_status !== want.clamp_status) begin
					$error("clamp_status: expected %0d, got %0d",
						want.clamp_status, result_ch.clamp_status);
					fail_count++;
				end
			end
		end
	end

	initial begin : stimulus
		int       ph;
		int       n;
		int       r;
		int       mag;
		bit       wind;
		bit       wind_neg;
		word_t    err;
		word_t    dt;
		word_t    lim_a;
		word_t    lim_b;
		word_t    up_v;
		word_t    lo_v;
		pid_out_t typed_out;

		arst_n                 = 1'b0;
		sample_ch.valid        = 1'b0;
		sample_ch.error_sample = '0;
		sample_ch.time_step    = '0;
		psel                   = 1'b0;
		penable                = 1'b0;
		pwrite                 = 1'b0;
		paddr                  = '0;
		pwdata                 = '0;

		dir_rows = '{
			'{ROW_ITEM,  3'd0,            16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0000, ST_NONE},
			'{ROW_ITEM,  3'd0,            16'h0000, 16'h7FFF, 16'hFFFF, 1'b1, 16'h0000, ST_NONE},
			'{ROW_ITEM,  3'd0,            16'h0000, 16'h8000, 16'hFFFF, 1'b1, 16'h0000, ST_NONE},
			'{ROW_WRITE, IDX_KP,          16'h7FFF, 16'h0000, 16'h0000, 1'b0, 16'h0000, ST_NONE},
			'{ROW_ITEM,  3'd0,            16'h0000, 16'h7FFF, 16'h4000, 1'b1, 16'h7FFF, ST_UPPER},
			'{ROW_ITEM,  3'd0,            16'h0000, 16'h8000, 16'h0001, 1'b1, 16'h8000, ST_LOWER},
			'{ROW_ITEM,  3'd0,            16'h0000, 16'h0001, 16'h4000, 1'b0, 16'h0000, ST_NONE},
			'{ROW_WRITE, IDX_KP,          16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, ST_NONE},
			'{ROW_WRITE, IDX_KI,          16'h8000, 16'h0000, 16'h0000, 1'b0, 16'h0000, ST_NONE},
			'{ROW_ITEM,  3'd0,            16'h0000, 16'h7FFF, 16'hFFFF, 1'b0, 16'h0000, ST_NONE},
			'{ROW_ITEM,  3'd0,            16'h0000, 16'hFFFF, 16'h0003, 1'b0, 16'h0000, ST_NONE},
			'{ROW_WRITE, IDX_KI,          16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, ST_NONE},
			'{ROW_WRITE, IDX_KD,          16'h7FFF, 16'h0000, 16'h0000, 1'b0, 16'h0000, ST_NONE},
			'{ROW_ITEM,  3'd0,            16'h0000, 16'h8000, 16'h0000, 1'b0, 16'h0000, ST_NONE},
			'{ROW_ITEM,  3'd0,            16'h0000, 16'h7FFF, 16'h0010, 1'b0, 16'h0000, ST_NONE},
			'{ROW_ITEM,  3'd0,            16'h0000, 16'h8000, 16'h0011, 1'b1, 16'h8000, ST_LOWER},
			'{ROW_WRITE, IDX_KD,          16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, ST_NONE},
			'{ROW_WRITE, IDX_KP,          16'h0100, 16'h0000, 16'h0000, 1'b0, 16'h0000, ST_NONE},
			'{ROW_WRITE, IDX_UPPER,       16'hFF9C, 16'h0000, 16'h0000, 1'b0, 16'h0000, ST_NONE},
			'{ROW_WRITE, IDX_LOWER,       16'h0064, 16'h0000, 16'h0000, 1'b0, 16'h0000, ST_NONE},
			'{ROW_ITEM,  3'd0,            16'h0000, 16'hFF38, 16'h0064, 1'b1, 16'h0064, ST_LOWER},
			'{ROW_ITEM,  3'd0,            16'h0000, 16'h0000, 16'h00C8, 1'b1, 16'hFF9C, ST_UPPER},
			'{ROW_WRITE, UNMAPPED_IDX_LO, 16'h4000, 16'h0000, 16'h0000, 1'b0, 16'h0000, ST_NONE},
			'{ROW_WRITE, UNMAPPED_IDX_HI, 16'h7FFF, 16'h0000, 16'h0000, 1'b0, 16'h0000, ST_NONE},
			'{ROW_ITEM,  3'd0,            16'h0000, 16'h0032, 16'h012C, 1'b1, 16'hFF9C, ST_UPPER}
		};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (n = 0; n < DIR_ROWS; n++) begin
			if (dir_rows[n].kind == ROW_WRITE) begin
				wait_idle();
				reg_write(dir_rows[n].reg_idx, dir_rows[n].wdata);
			end else begin
				typed_out.control_value = dir_rows[n].exp_value;
				typed_out.clamp_status  = dir_rows[n].exp_status;
				send_sample(dir_rows[n].err, dir_rows[n].dt, dir_rows[n].typed, typed_out);
			end
		end

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			wait_idle();
			gaps_on = (ph % 3) != 2;
			lim_a = word_t'($urandom);
			lim_b = word_t'($urandom);
			if ($signed(lim_a) > $signed(lim_b)) begin
				up_v = lim_a;
				lo_v = lim_b;
			end else begin
				up_v = lim_b;
				lo_v = lim_a;
			end
			case (ph)
				0: begin
					reg_write(IDX_KP, 16'h7FFF);
					reg_write(IDX_KI, 16'h7FFF);
					reg_write(IDX_KD, 16'h7FFF);
					up_v = 16'h7FFF;
					lo_v = 16'h8000;
				end
				1: begin
					reg_write(IDX_KP, 16'h8000);
					reg_write(IDX_KI, 16'h8000);
					reg_write(IDX_KD, 16'h8000);
					up_v = 16'h7FFF;
					lo_v = 16'h8000;
				end
				default: begin
					reg_write(IDX_KP, pick_gain());
					reg_write(IDX_KI, pick_gain());
					reg_write(IDX_KD, pick_gain());
					if (ph == 2) begin
						lo_v = up_v;
					end else begin
						case ($urandom_range(0, 3))
							0: begin
								up_v = 16'h7FFF;
								lo_v = 16'h8000;
							end
							1: ;
							2: begin
								lim_a = up_v;
								up_v  = lo_v;
								lo_v  = lim_a;
							end
							default: begin
								up_v = word_t'($urandom_range(0, 2000));
								lo_v = word_t'(-int'($urandom_range(0, 2000)));
							end
						endcase
					end
				end
			endcase
			reg_write(IDX_UPPER, up_v);
			reg_write(IDX_LOWER, lo_v);
			if ($urandom_range(0, 2) == 0)
				reg_write(3'($urandom_range(UNMAPPED_IDX_LO, UNMAPPED_IDX_HI)),
					word_t'($urandom));

			wind     = (ph == 3) || (ph == 4) || (ph > 4 && $urandom_range(0, 3) == 0);
			wind_neg = (ph == 4) || (ph > 4 && $urandom_range(0, 1) == 1);

			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (wind) begin
					mag = $urandom_range(30000, 32767);
					err = word_t'(wind_neg ? -mag - 1 : mag);
					dt  = word_t'($urandom_range(60000, 65535));
				end else begin
					r = $urandom_range(0, 4);
					case (r)
						1: case ($urandom_range(0, 4))
							0: err = 16'h7FFF;
							1: err = 16'h8000;
							2: err = 16'h0000;
							3: err = 16'hFFFF;
							default: err = 16'h0001;
						endcase
						2: err = word_t'(int'($urandom_range(0, 1200)) - 600);
						default: err = word_t'($urandom);
					endcase
					r = $urandom_range(0, 4);
					case (r)
						0: dt = word_t'($urandom_range(0, 16));
						1: case ($urandom_range(0, 4))
							0: dt = 16'd16;
							1: dt = 16'd17;
							2: dt = 16'd16384;
							3: dt = 16'hFFFF;
							default: dt = 16'd0;
						endcase
						default: dt = word_t'($urandom);
					endcase
				end
				typed_out = '0;
				send_sample(err, dt, 1'b0, typed_out);
				if ($urandom_range(0, 199) == 0)
					wait_idle();
			end
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (pending_outputs.size() != 0) begin
			$error("%0d expected results never arrived", pending_outputs.size());
			fail_count++;
		end

		$display("Run covered %0d samples over %0d gain and limit settings, %0d results checked.",
			samples_sent, NUM_PHASES + 1, results_seen);
		$display("Outputs within limits %0d, at upper %0d, at lower %0d; integral saturated %0d times.",
			status_hits[ST_NONE], status_hits[ST_UPPER], status_hits[ST_LOWER],
			sat_hits);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/pidc_pkg.sv
hdl/pidc_if.sv
hdl/pid_controller_clamped.sv
tb/tb.sv
